// ===== hw/rtl/ed_pkg.sv =====
// Shared widths, constants and control/status types of the Euclidean distance unit.
package ed_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int DIFF_WIDTH     = SAMPLE_WIDTH + 1;
    localparam int SQ_WIDTH       = 2 * DIFF_WIDTH;
    localparam int ACC_WIDTH      = 42;
    localparam int DIST_WIDTH     = 21;
    localparam int LEN_WIDTH      = 11;
    localparam int MAX_DIMENSION  = 1024;
    localparam int LEN_RESET      = 128;
    localparam int ROOT_START_EXP = 2 * (DIST_WIDTH - 1);

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic [DIST_WIDTH-1:0]          t_dist;
    typedef logic [LEN_WIDTH-1:0]           t_len;

    typedef struct packed {
        logic load_diff;
        logic do_square;
        logic do_accum;
        logic sqrt_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_last;
        logic sqrt_done;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hw/rtl/ed_in_if.sv =====
// Input channel: one beat carries a pair of matching vector elements.
interface ed_in_if import ed_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample first_element;
    t_sample second_element;

    modport source (output valid, output first_element, output second_element, input ready);
    modport sink   (input valid, input first_element, input second_element, output ready);
endinterface

// ===== hw/rtl/ed_out_if.sv =====
// Output channel: one beat carries one distance.
interface ed_out_if import ed_pkg::*; ();
    logic  valid;
    logic  ready;
    t_dist distance;

    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface

// ===== hw/rtl/euclidean_distance_unit.sv =====
// Top level of the Euclidean distance unit: controller, datapath and channel wiring.
// Element beat: after acceptance, the difference, square and accumulate steps run before the next ready.
// Last element of a vector: a further bit-pair square root, one root bit per
// cycle in a single shared add/compare unit, then the output register is loaded once it is free.
// A distance waits in the output register while the next vector's elements are taken.
// Reset (synchronous, active low) clears the sum, count and output valid; length returns to 128.
module euclidean_distance_unit import ed_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  t_len      i_cfg_wdata,
    ed_in_if.sink     i_in,
    ed_out_if.source  o_out
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    ed_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    ed_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_first_element  (i_in.first_element),
        .i_second_element (i_in.second_element),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_distance       (o_out.distance)
    );

endmodule

// ===== hw/rtl/ed_ctrl.sv =====
// Controller state machine: sequences difference, square, accumulate, square-root and output-load steps.
module ed_ctrl import ed_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SQUARE = 2'd1;
    localparam logic [1:0] ST_ACCUM  = 2'd2;
    localparam logic [1:0] ST_ROOT   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_diff = 1'b1;
                    n_state         = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                o_cmd.do_square = 1'b1;
                n_state         = ST_ACCUM;
            end
            ST_ACCUM: begin
                o_cmd.do_accum = 1'b1;
                n_state        = i_status.is_last ? ST_ROOT : ST_IDLE;
            end
            ST_ROOT: begin
                if (!i_status.sqrt_done) begin
                    o_cmd.sqrt_step = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");

    a_accum_follows_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.do_square |=> o_cmd.do_accum)
        else $error("square not followed by accumulate");

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_diff |=> !o_in_ready)
        else $error("input taken again while element in flight");

endmodule

// ===== hw/rtl/ed_datapath.sv =====
// Datapath: difference, square, saturating accumulator, bit-pair square root, output register.
module ed_datapath import ed_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  t_len       i_cfg_wdata,
    input  t_sample    i_first_element,
    input  t_sample    i_second_element,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dist      o_distance
);

    t_len                  r_len;
    t_len                  r_count;
    logic [DIFF_WIDTH-1:0] r_diff_abs;
    logic [SQ_WIDTH-1:0]   r_sq;
    logic [ACC_WIDTH-1:0]  r_sum;
    logic [ACC_WIDTH-1:0]  r_rem;
    logic [ACC_WIDTH-1:0]  r_root;
    logic [ACC_WIDTH-1:0]  r_bit;
    logic                  r_out_valid;
    t_dist                 r_out_dist;

    logic signed [DIFF_WIDTH-1:0] diff;
    logic [DIFF_WIDTH-1:0]        n_diff_abs;
    logic [SQ_WIDTH-1:0]          n_sq;
    logic [ACC_WIDTH:0]           sum_wide;
    logic [ACC_WIDTH-1:0]         n_sum;
    t_len                         len_eff;
    t_len                         n_count;
    logic                         is_last;
    logic [ACC_WIDTH:0]           trial;
    logic                         take;
    logic [ACC_WIDTH-1:0]         n_root;

    assign diff       = {i_first_element[SAMPLE_WIDTH-1], i_first_element}
                      - {i_second_element[SAMPLE_WIDTH-1], i_second_element};
    assign n_diff_abs = diff[DIFF_WIDTH-1] ? DIFF_WIDTH'(-diff) : DIFF_WIDTH'(diff);
    assign n_sq       = SQ_WIDTH'(r_diff_abs) * SQ_WIDTH'(r_diff_abs);

    assign sum_wide = {1'b0, r_sum} + {{(ACC_WIDTH + 1 - SQ_WIDTH){1'b0}}, r_sq};
    assign n_sum    = sum_wide[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : sum_wide[ACC_WIDTH-1:0];

    always_comb begin
        if (r_len == '0) begin
            len_eff = LEN_WIDTH'(1);
        end else if (r_len > LEN_WIDTH'(MAX_DIMENSION)) begin
            len_eff = LEN_WIDTH'(MAX_DIMENSION);
        end else begin
            len_eff = r_len;
        end
    end

    assign n_count = r_count + LEN_WIDTH'(1);
    assign is_last = (n_count >= len_eff) || (n_count == '0);

    assign trial  = {1'b0, r_root} + {1'b0, r_bit};
    assign take   = ({1'b0, r_rem} >= trial);
    assign n_root = take ? ((r_root >> 1) + r_bit) : (r_root >> 1);

    assign o_status.is_last   = is_last;
    assign o_status.sqrt_done = (r_bit == '0);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_out_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LEN_WIDTH'(LEN_RESET);
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            if (i_cmd.do_accum) begin
                if (is_last) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= n_sum;
                    r_count <= n_count;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_diff) begin
            r_diff_abs <= n_diff_abs;
        end
        if (i_cmd.do_square) begin
            r_sq <= n_sq;
        end
        if (i_cmd.do_accum && is_last) begin
            r_rem  <= n_sum;
            r_root <= '0;
            r_bit  <= ACC_WIDTH'(1) << ROOT_START_EXP;
        end else if (i_cmd.sqrt_step) begin
            if (take) begin
                r_rem <= r_rem - trial[ACC_WIDTH-1:0];
            end
            r_root <= n_root;
            r_bit  <= r_bit >> 2;
        end
        if (i_cmd.load_out) begin
            r_out_dist <= r_root[DIST_WIDTH-1:0];
        end
    end

    a_load_after_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (r_bit == '0))
        else $error("distance loaded before square root finished");

    a_step_has_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sqrt_step |-> (r_bit != '0))
        else $error("square root step after completion");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("loaded distance not presented");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for euclidean_distance_unit: streams element pairs, predicts each distance.
module tb;
    import ed_pkg::*;

    localparam int          SETTLE_CYCLES  = 40;
    localparam int          TAIL_CYCLES    = 60;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          RANDOM_ITEMS   = 900;
    localparam logic [63:0] ACC_LIMIT      = (64'd1 << ACC_WIDTH) - 64'd1;

    typedef enum logic {JOB_PAIR, JOB_LENGTH} t_job_kind;

    typedef struct {
        t_job_kind kind;
        t_sample   a;
        t_sample   b;
        t_len      length;
    } t_job;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_len i_cfg_wdata;

    ed_in_if  in_if ();
    ed_out_if out_if ();

    euclidean_distance_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    t_job        job_q[$];
    t_dist       dist_q[$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;

    // predictor state
    t_len        len_reg;
    t_len        elem_count;
    logic [63:0] sq_sum;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2, 3: return t_sample'(int'($urandom_range(0, 511)) - 256);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_dist floor_root(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = DIST_WIDTH - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n) root = trial;
        end
        return t_dist'(root);
    endfunction

    task automatic absorb_pair(input t_sample a, input t_sample b);
        longint      d;
        logic [63:0] mag;
        int          eff_len;
        d   = longint'(a) - longint'(b);
        mag = (d < 0) ? 64'(-d) : 64'(d);
        sq_sum = sq_sum + mag * mag;
        if (sq_sum > ACC_LIMIT) sq_sum = ACC_LIMIT;
        eff_len = int'(len_reg);
        if (eff_len == 0) eff_len = 1;
        if (eff_len > MAX_DIMENSION) eff_len = MAX_DIMENSION;
        elem_count = elem_count + t_len'(1);
        if (int'(elem_count) >= eff_len || elem_count == '0) begin
            dist_q.push_back(floor_root(sq_sum));
            sq_sum     = '0;
            elem_count = '0;
        end
    endtask

    task automatic queue_pair(input t_sample a, input t_sample b);
        t_job j;
        j.kind   = JOB_PAIR;
        j.a      = a;
        j.b      = b;
        j.length = '0;
        job_q.push_back(j);
    endtask

    task automatic queue_length(input t_len v);
        t_job j;
        j.kind   = JOB_LENGTH;
        j.a      = '0;
        j.b      = '0;
        j.length = v;
        job_q.push_back(j);
    endtask

    // driver: input beats and register writes
    int in_gap  = 0;
    int in_calm = 0;
    int settle  = 0;

    always @(posedge i_clk) begin
        logic valid_n;
        logic we_n;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            i_cfg_we    <= 1'b0;
            in_gap      = 0;
            settle      = 0;
            len_reg     = t_len'(LEN_RESET);
            elem_count  = '0;
            sq_sum      = '0;
        end else begin
            valid_n = in_if.valid;
            we_n    = 1'b0;
            if (in_if.valid && in_if.ready) begin
                absorb_pair(in_if.first_element, in_if.second_element);
                valid_n = 1'b0;
                if (in_calm > 0) begin
                    in_calm--;
                    in_gap = 0;
                end else begin
                    in_gap = draw_gap();
                    if ($urandom_range(0, 63) == 0) in_calm = $urandom_range(30, 120);
                end
            end
            if (!valid_n) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (job_q.size() != 0) begin
                    if (job_q[0].kind == JOB_PAIR) begin
                        in_if.first_element  <= job_q[0].a;
                        in_if.second_element <= job_q[0].b;
                        valid_n = 1'b1;
                        void'(job_q.pop_front());
                    end else if (dist_q.size() != 0) begin
                        settle = 0;
                    end else if (settle < SETTLE_CYCLES) begin
                        settle++;
                    end else begin
                        // block idle and drained: safe to change the length
                        we_n        = 1'b1;
                        i_cfg_wdata <= job_q[0].length;
                        len_reg     = job_q[0].length;
                        settle      = 0;
                        void'(job_q.pop_front());
                    end
                end
            end
            in_if.valid <= valid_n;
            i_cfg_we    <= we_n;
        end
    end

    // monitor: output beats against predicted distances
    int out_stall = 0;
    int out_calm  = 0;

    always @(posedge i_clk) begin
        t_dist expected;
        logic  ready_n;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            out_stall    = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (dist_q.size() == 0) begin
                    $display("%0t: unexpected distance, expected none, got %0d",
                             $time, out_if.distance);
                    mismatch_count++;
                end else begin
                    expected = dist_q.pop_front();
                    if (out_if.distance !== expected) begin
                        $display("%0t: distance mismatch, expected %0d, got %0d",
                                 $time, expected, out_if.distance);
                        mismatch_count++;
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                ready_n = 1'b0;
            end else if (out_calm > 0) begin
                out_calm--;
                ready_n = 1'b1;
            end else begin
                if ($urandom_range(0, 3) == 0) out_stall = draw_gap();
                if ($urandom_range(0, 127) == 0) out_calm = $urandom_range(40, 160);
                ready_n = (out_stall == 0);
            end
            out_if.ready <= ready_n;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int    r;
        int    n;
        int    vec;
        int    rand_items;
        t_len  len;

        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = '0;
        in_if.valid          = 1'b0;
        in_if.first_element  = '0;
        in_if.second_element = '0;
        out_if.ready         = 1'b0;

        // reset length: one vector of 128 opening with the extreme pairs
        queue_pair(16'sh7FFF, 16'sh8000);
        queue_pair(16'sh8000, 16'sh7FFF);
        queue_pair(16'sh7FFF, 16'sh7FFF);
        queue_pair(16'sh8000, 16'sh8000);
        for (int k = 4; k < LEN_RESET; k++) queue_pair(pick_sample(), pick_sample());

        // zero length acts as one: each beat is a whole vector
        queue_length('0);
        queue_pair(16'sh7FFF, 16'sh8000);
        queue_pair(16'sh8000, 16'sh7FFF);
        queue_pair(16'sh0000, 16'sh0000);
        queue_pair(16'shFFFF, 16'sh0000);
        queue_pair(16'sh0001, 16'shFFFF);
        queue_pair(16'sh5555, 16'shAAAA);
        queue_pair(16'sh0100, 16'sh0000);

        // length cut below the count mid-vector: next beat closes the vector
        queue_length(t_len'(MAX_DIMENSION));
        repeat (4) queue_pair(pick_sample(), pick_sample());
        queue_length(t_len'(3));
        queue_pair(16'sh1234, 16'shEDCB);

        // over-range length, then cut to one after two beats
        queue_length(t_len'(MAX_DIMENSION + 1));
        repeat (2) queue_pair(pick_sample(), pick_sample());
        queue_length(t_len'(1));
        queue_pair(16'sh8000, 16'sh0000);

        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70)      len = t_len'($urandom_range(1, 8));
            else if (r < 90) len = t_len'($urandom_range(9, 40));
            else if (r < 95) len = '0;
            else             len = t_len'($urandom_range(41, 160));
            queue_length(len);
            vec = (len == '0) ? 1 : int'(len);
            n   = vec * $urandom_range(1, 4);
            if ($urandom_range(0, 3) == 0) n += $urandom_range(1, vec);
            repeat (n) queue_pair(pick_sample(), pick_sample());
            rand_items += n;
        end

        queue_length(t_len'(2));
        repeat (6) queue_pair(pick_sample(), pick_sample());

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (job_q.size() != 0 || in_if.valid) @(posedge i_clk);
        while (dist_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && dist_q.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
